/* design/ps2mct_pkg.sv */
// Package for the PS/2 mouse packet cursor tracker.
// Holds the widths, codes, reset values, the result struct and the clamp helpers.
// No dependencies; used by ps2mct_core, the top level and the checker.
`default_nettype none

package ps2mct_pkg;

   // Width of the internal cursor registers.
   localparam int COORD_WIDTH = 12;
   localparam int COORD_MAX   = (1 << COORD_WIDTH) - 1;

   // Fixed widths of the transaction fields and registers.
   localparam int BYTE_WIDTH      = 8;
   localparam int POS_WIDTH       = 12;
   localparam int BUTTON_WIDTH    = 3;
   localparam int SIZE_WIDTH      = 13;
   localparam int CSR_INDEX_WIDTH = 2;
   localparam int CSR_DATA_WIDTH  = SIZE_WIDTH;

   // Compare width for a screen size against the coordinate range.
   localparam int LIM_WIDTH = (SIZE_WIDTH > COORD_WIDTH) ? SIZE_WIDTH + 1 : COORD_WIDTH + 1;
   // Signed width of cursor plus or minus a 9-bit delta.
   localparam int SUM_WIDTH = COORD_WIDTH + 2;
   localparam int DELTA_WIDTH = BYTE_WIDTH + 1;

   // Register indexes.
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SCREEN_WIDTH  = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SCREEN_HEIGHT = 2'd1;

   // Status byte bits and special codes.
   localparam logic [BYTE_WIDTH-1:0] STATUS_SYNC_MASK = 8'h08;
   localparam logic [BYTE_WIDTH-1:0] ACK_CODE         = 8'hFA;
   localparam int STATUS_X_SIGN_BIT = 4;
   localparam int STATUS_Y_SIGN_BIT = 5;
   localparam int STATUS_X_OVF_BIT  = 6;
   localparam int STATUS_Y_OVF_BIT  = 7;

   localparam logic [SIZE_WIDTH-1:0] SCREEN_WIDTH_RESET  = 13'd800;
   localparam logic [SIZE_WIDTH-1:0] SCREEN_HEIGHT_RESET = 13'd600;

   localparam logic [COORD_WIDTH-1:0] CURSOR_COL_RESET =
      COORD_WIDTH'((400 > COORD_MAX) ? COORD_MAX : 400);
   localparam logic [COORD_WIDTH-1:0] CURSOR_ROW_RESET =
      COORD_WIDTH'((300 > COORD_MAX) ? COORD_MAX : 300);

   // Where the framer stands within a three-byte packet.
   typedef enum logic [1:0] {
      POS_STATUS,
      POS_XDELTA,
      POS_YDELTA
   } pos_type;

   // One result transaction.
   typedef struct packed {
      logic [POS_WIDTH-1:0]    pos_x;
      logic [POS_WIDTH-1:0]    pos_y;
      logic [BUTTON_WIDTH-1:0] button_bits;
      logic                    packet_done;
      logic                    byte_dropped;
      logic                    motion_ignored;
   } rsp_type;

   // Largest coordinate for a screen size: size minus one, with zero acting as one
   // and the result saturated to the coordinate range.
   function automatic logic [COORD_WIDTH-1:0] limit_of(input logic [SIZE_WIDTH-1:0] size);
      logic [LIM_WIDTH-1:0] lim;
      begin
         lim = (size == '0) ? '0 : LIM_WIDTH'(size) - LIM_WIDTH'(1);
         if (lim > LIM_WIDTH'(COORD_MAX)) begin
            lim = LIM_WIDTH'(COORD_MAX);
         end
         return lim[COORD_WIDTH-1:0];
      end
   endfunction

   // Clamp a signed sum into [0, lim].
   function automatic logic [COORD_WIDTH-1:0] clamp_to(input logic signed [SUM_WIDTH-1:0] v,
                                                       input logic [COORD_WIDTH-1:0] lim);
      logic [COORD_WIDTH-1:0] r;
      begin
         if (v < 0) begin
            r = '0;
         end else if (v > $signed({2'b00, lim})) begin
            r = lim;
         end else begin
            r = v[COORD_WIDTH-1:0];
         end
         return r;
      end
   endfunction

   // Cursor register to output field: mask or zero-extend to the field width.
   function automatic logic [POS_WIDTH-1:0] to_pos(input logic [COORD_WIDTH-1:0] c);
      logic [31:0] wide;
      begin
         wide = 32'(c);
         return wide[POS_WIDTH-1:0];
      end
   endfunction

endpackage

`default_nettype wire

/* design/ps2mct_core.sv */
// Packet framer and cursor state for the PS/2 mouse tracker.
// Depends on ps2mct_pkg. Gives the result of the byte offered this cycle and
// updates its state when the byte is taken.
`default_nettype none

module ps2mct_core (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  csr_write_enable,
   input  wire logic [ps2mct_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire logic [ps2mct_pkg::CSR_DATA_WIDTH-1:0]  csr_write_data,
   input  wire logic                                  step,
   input  wire logic [ps2mct_pkg::BYTE_WIDTH-1:0]      rx_byte,
   output ps2mct_pkg::rsp_type                        result
);

   ps2mct_pkg::pos_type pos_ff, pos_in;

   logic [ps2mct_pkg::BYTE_WIDTH-1:0]   status_ff;
   logic [ps2mct_pkg::BYTE_WIDTH-1:0]   xbyte_ff;
   logic [ps2mct_pkg::COORD_WIDTH-1:0]  col_ff, col_in;
   logic [ps2mct_pkg::COORD_WIDTH-1:0]  row_ff, row_in;
   logic [ps2mct_pkg::BUTTON_WIDTH-1:0] buttons_ff, buttons_in;
   logic [ps2mct_pkg::COORD_WIDTH-1:0]  limit_x_ff, limit_y_ff;

   logic reject;
   logic done;
   logic dropped;
   logic overflow;
   logic signed [ps2mct_pkg::DELTA_WIDTH-1:0] dx, dy;
   logic signed [ps2mct_pkg::SUM_WIDTH-1:0]   col_sum, row_sum;

   // A status byte must have bit 3 set and must not be the ACK code.
   assign reject = ((rx_byte & ps2mct_pkg::STATUS_SYNC_MASK) == '0) ||
                   (rx_byte == ps2mct_pkg::ACK_CODE);

   // Next framer position.
   always_comb begin
      unique case (pos_ff)
         ps2mct_pkg::POS_STATUS: pos_in = reject ? ps2mct_pkg::POS_STATUS
                                                 : ps2mct_pkg::POS_XDELTA;
         ps2mct_pkg::POS_XDELTA: pos_in = ps2mct_pkg::POS_YDELTA;
         ps2mct_pkg::POS_YDELTA: pos_in = ps2mct_pkg::POS_STATUS;
         default:                pos_in = ps2mct_pkg::POS_STATUS;
      endcase
   end

   // Flags per position.
   always_comb begin
      done    = 1'b0;
      dropped = 1'b0;
      unique case (pos_ff)
         ps2mct_pkg::POS_STATUS: dropped = reject;
         ps2mct_pkg::POS_XDELTA: done    = 1'b0;
         ps2mct_pkg::POS_YDELTA: done    = 1'b1;
         default:                done    = 1'b0;
      endcase
   end

   // Motion datapath: sign-extend the deltas, add X, subtract Y, clamp.
   assign dx = $signed({status_ff[ps2mct_pkg::STATUS_X_SIGN_BIT], xbyte_ff});
   assign dy = $signed({status_ff[ps2mct_pkg::STATUS_Y_SIGN_BIT], rx_byte});
   assign overflow = status_ff[ps2mct_pkg::STATUS_X_OVF_BIT] |
                     status_ff[ps2mct_pkg::STATUS_Y_OVF_BIT];

   assign col_sum = $signed({2'b00, col_ff}) + ps2mct_pkg::SUM_WIDTH'(dx);
   assign row_sum = $signed({2'b00, row_ff}) - ps2mct_pkg::SUM_WIDTH'(dy);

   always_comb begin
      col_in     = col_ff;
      row_in     = row_ff;
      buttons_in = buttons_ff;
      if (done) begin
         buttons_in = status_ff[ps2mct_pkg::BUTTON_WIDTH-1:0];
         if (!overflow) begin
            col_in = ps2mct_pkg::clamp_to(col_sum, limit_x_ff);
            row_in = ps2mct_pkg::clamp_to(row_sum, limit_y_ff);
         end
      end
   end

   always_comb begin
      result.pos_x          = ps2mct_pkg::to_pos(col_in);
      result.pos_y          = ps2mct_pkg::to_pos(row_in);
      result.button_bits    = buttons_in;
      result.packet_done    = done;
      result.byte_dropped   = dropped;
      result.motion_ignored = done & overflow;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff     <= ps2mct_pkg::POS_STATUS;
         col_ff     <= ps2mct_pkg::CURSOR_COL_RESET;
         row_ff     <= ps2mct_pkg::CURSOR_ROW_RESET;
         buttons_ff <= '0;
      end else if (step) begin
         pos_ff     <= pos_in;
         col_ff     <= col_in;
         row_ff     <= row_in;
         buttons_ff <= buttons_in;
      end
   end

   // Held packet bytes need no reset: each is written before it is read.
   always_ff @(posedge clock) begin
      if (step && (pos_ff == ps2mct_pkg::POS_STATUS) && !reject) begin
         status_ff <= rx_byte;
      end
      if (step && (pos_ff == ps2mct_pkg::POS_XDELTA)) begin
         xbyte_ff <= rx_byte;
      end
   end

   // Screen sizes are kept as coordinate limits; a write does not move the cursor.
   always_ff @(posedge clock) begin
      if (reset) begin
         limit_x_ff <= ps2mct_pkg::limit_of(ps2mct_pkg::SCREEN_WIDTH_RESET);
         limit_y_ff <= ps2mct_pkg::limit_of(ps2mct_pkg::SCREEN_HEIGHT_RESET);
      end else if (csr_write_enable) begin
         unique case (csr_index)
            ps2mct_pkg::CSR_SCREEN_WIDTH:  limit_x_ff <= ps2mct_pkg::limit_of(csr_write_data);
            ps2mct_pkg::CSR_SCREEN_HEIGHT: limit_y_ff <= ps2mct_pkg::limit_of(csr_write_data);
            default: begin
            end
         endcase
      end
   end

endmodule

`default_nettype wire

/* design/ps2_mouse_packet_cursor_tracker.sv */
// Top level of the PS/2 mouse packet cursor tracker.
// Depends on ps2mct_pkg and ps2mct_core; adds the result register and skid stage.
//
// Channel   Direction  Handshake          Payload
// req_      in         req_valid/stall    req_rx_byte
// rsp_      out        rsp_valid/stall    pos_x, pos_y, button_bits, flags
// csr_      in         csr_write_enable   csr_index, csr_write_data
//
// Every raw byte gives exactly one result transaction, registered after it is taken.
// A byte can be taken in every cycle while req_stall is low; the rate is then one
// transaction per cycle; the framer and clamp in ps2mct_core feed the result register.
// Reset is synchronous and active high; it restores the cursor to the screen center,
// the screen size to 800 by 600 and the framer to wait for a status byte.
// When the result side stalls, one more result is parked in a skid register; req_stall
// rises only while that skid register is full.
`default_nettype none

module ps2_mouse_packet_cursor_tracker (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   req_valid,
   output      logic                                   req_stall,
   input  wire logic [ps2mct_pkg::BYTE_WIDTH-1:0]      req_rx_byte,
   output      logic                                   rsp_valid,
   input  wire logic                                   rsp_stall,
   output      logic [ps2mct_pkg::POS_WIDTH-1:0]       rsp_pos_x,
   output      logic [ps2mct_pkg::POS_WIDTH-1:0]       rsp_pos_y,
   output      logic [ps2mct_pkg::BUTTON_WIDTH-1:0]    rsp_button_bits,
   output      logic                                   rsp_packet_done,
   output      logic                                   rsp_byte_dropped,
   output      logic                                   rsp_motion_ignored,
   input  wire logic                                   csr_write_enable,
   input  wire logic [ps2mct_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire logic [ps2mct_pkg::CSR_DATA_WIDTH-1:0]  csr_write_data
);

   logic req_take;
   logic rsp_take;

   ps2mct_pkg::rsp_type new_result;
   ps2mct_pkg::rsp_type main_ff, main_in;
   ps2mct_pkg::rsp_type skid_ff, skid_in;
   logic                main_valid_ff, main_valid_in;
   logic                skid_valid_ff, skid_valid_in;

   // The core's state advances exactly when a byte transaction is taken.
   assign req_stall = skid_valid_ff;
   assign req_take  = req_valid & ~skid_valid_ff;
   assign rsp_take  = main_valid_ff & ~rsp_stall;

   ps2mct_core u_core (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .step             (req_take),
      .rx_byte          (req_rx_byte),
      .result           (new_result)
   );

   // Result register plus skid. A new result goes to the result register when it is
   // free or draining this cycle, otherwise into the skid register. A full skid
   // refills the result register as soon as the consumer takes the current one.
   always_comb begin
      main_in       = main_ff;
      skid_in       = skid_ff;
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      if (skid_valid_ff) begin
         if (rsp_take) begin
            main_in       = skid_ff;
            skid_valid_in = 1'b0;
         end
      end else if (req_take) begin
         if (!main_valid_ff || rsp_take) begin
            main_in       = new_result;
            main_valid_in = 1'b1;
         end else begin
            skid_in       = new_result;
            skid_valid_in = 1'b1;
         end
      end else if (rsp_take) begin
         main_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid          = main_valid_ff;
   assign rsp_pos_x          = main_ff.pos_x;
   assign rsp_pos_y          = main_ff.pos_y;
   assign rsp_button_bits    = main_ff.button_bits;
   assign rsp_packet_done    = main_ff.packet_done;
   assign rsp_byte_dropped   = main_ff.byte_dropped;
   assign rsp_motion_ignored = main_ff.motion_ignored;

endmodule

`default_nettype wire

/* design/ps2mct_checker.sv */
// Port-level checker for the PS/2 mouse packet cursor tracker, and its bind.
// Depends on ps2mct_pkg; watches only the top level's result ports.
`default_nettype none

module ps2mct_checker (
   input wire logic                                   clock,
   input wire logic                                   reset,
   input wire logic                                   rsp_valid,
   input wire logic                                   rsp_stall,
   input wire logic [ps2mct_pkg::POS_WIDTH-1:0]       rsp_pos_x,
   input wire logic [ps2mct_pkg::POS_WIDTH-1:0]       rsp_pos_y,
   input wire logic [ps2mct_pkg::BUTTON_WIDTH-1:0]    rsp_button_bits,
   input wire logic                                   rsp_packet_done,
   input wire logic                                   rsp_byte_dropped,
   input wire logic                                   rsp_motion_ignored
);

   logic                                rsp_take;
   logic                                seen_ff;
   logic [ps2mct_pkg::POS_WIDTH-1:0]    last_x_ff;
   logic [ps2mct_pkg::POS_WIDTH-1:0]    last_y_ff;
   logic [ps2mct_pkg::BUTTON_WIDTH-1:0] last_buttons_ff;

   assign rsp_take = rsp_valid & ~rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff <= 1'b0;
      end else if (rsp_take) begin
         seen_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_take) begin
         last_x_ff       <= rsp_pos_x;
         last_y_ff       <= rsp_pos_y;
         last_buttons_ff <= rsp_button_bits;
      end
   end

   // A byte cannot both finish a packet and be thrown away.
   a_done_xor_drop: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_packet_done && rsp_byte_dropped))
      else $error("packet_done and byte_dropped both set");

   // Ignored motion is only reported on a completed packet.
   a_ignored_needs_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_motion_ignored |-> rsp_packet_done)
      else $error("motion_ignored without packet_done");

   // Cursor and buttons only move when a packet completes.
   a_hold_between_packets: assert property (@(posedge clock) disable iff (reset)
      rsp_take && seen_ff && !rsp_packet_done |->
         (rsp_pos_x == last_x_ff) && (rsp_pos_y == last_y_ff) &&
         (rsp_button_bits == last_buttons_ff))
      else $error("cursor or buttons changed without a packet");

   // An overflowed packet leaves the cursor where it was.
   a_overflow_holds_cursor: assert property (@(posedge clock) disable iff (reset)
      rsp_take && seen_ff && rsp_motion_ignored |->
         (rsp_pos_x == last_x_ff) && (rsp_pos_y == last_y_ff))
      else $error("cursor moved on an overflowed packet");

   // A stalled result stays valid and keeps its position, buttons and packet_done flag.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_pos_x) && $stable(rsp_pos_y) &&
         $stable(rsp_button_bits) && $stable(rsp_packet_done))
      else $error("stalled result changed");

endmodule

bind ps2_mouse_packet_cursor_tracker ps2mct_checker u_ps2mct_checker (.*);

`default_nettype wire
